// ----- design/wpm_pkg.sv -----
// ---------------------------------------------------------------------------
// wpm_pkg
// Shared types, register codes and byte classification helpers for the
// word-prefix text matcher.
// ---------------------------------------------------------------------------
package wpm_pkg;

  localparam int NEEDLE_BYTES = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int LEN_W        = 5;
  localparam int MATCH_OFF_W  = 16;

  typedef enum logic [1:0] {
    REG_NEEDLE_LOW  = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LEN  = 2'd2
  } wpm_reg_t;

  typedef struct packed {
    logic [8*NEEDLE_BYTES-1:0] needle;
    logic [LEN_W-1:0]          length;
  } wpm_cfg_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// ----- design/wpm_regs.sv -----
// ---------------------------------------------------------------------------
// wpm_regs
// APB configuration registers: needle bytes and needle length.
// ---------------------------------------------------------------------------
module wpm_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wpm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wpm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wpm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output wpm_pkg::wpm_cfg_t                  cfg
);

  logic [63:0]                   needle_low;
  logic [63:0]                   needle_high;
  logic [wpm_pkg::LEN_W-1:0]     needle_len;
  logic [1:0]                    reg_sel;
  logic                          wr_en;

  assign reg_sel = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low  <= '0;
      needle_high <= '0;
      needle_len  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        wpm_pkg::REG_NEEDLE_LOW:  needle_low  <= pwdata;
        wpm_pkg::REG_NEEDLE_HIGH: needle_high <= pwdata;
        wpm_pkg::REG_NEEDLE_LEN:  needle_len  <= pwdata[wpm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wpm_pkg::REG_NEEDLE_LOW:  prdata = needle_low;
      wpm_pkg::REG_NEEDLE_HIGH: prdata = needle_high;
      wpm_pkg::REG_NEEDLE_LEN:  prdata = 64'(needle_len);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.needle = {needle_high, needle_low};
  assign cfg.length = needle_len;

endmodule

// ----- design/wpm_match.sv -----
// ---------------------------------------------------------------------------
// wpm_match
// Shift-and candidate update for one text byte: case-folded compare against
// every needle byte, word-start gating and match start computation.
// ---------------------------------------------------------------------------
module wpm_match #(
  parameter int CAP         = 16,
  parameter int OFFSET_BITS = 16
) (
  input  wpm_pkg::wpm_cfg_t        cfg,
  input  logic [7:0]               text_byte,
  input  logic [CAP-1:0]           cand,
  input  logic                     prior_alnum,
  input  logic [OFFSET_BITS-1:0]   pos,
  output logic [CAP-1:0]           cand_next,
  output logic                     hit,
  output logic                     empty,
  output logic [OFFSET_BITS-1:0]   start,
  output logic                     alnum
);

  logic [wpm_pkg::LEN_W-1:0] len_c;
  logic [7:0]                fc;
  logic                      word_mode;
  logic                      may_start;
  logic [CAP-1:0]            cmask;
  logic [CAP-1:0]            lenmask;
  logic [CAP-1:0]            topbit;
  logic [OFFSET_BITS-1:0]    lm1;

  assign len_c = (cfg.length > wpm_pkg::LEN_W'(CAP)) ? wpm_pkg::LEN_W'(CAP) : cfg.length;
  assign empty = (len_c == '0);
  assign fc    = wpm_pkg::fold(text_byte);
  assign alnum = wpm_pkg::is_alnum(text_byte);

  assign word_mode = wpm_pkg::is_alnum(cfg.needle[7:0]);
  assign may_start = word_mode ? (alnum & ~prior_alnum) : 1'b1;

  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      cmask[k]   = (wpm_pkg::fold(cfg.needle[8*k +: 8]) == fc);
      lenmask[k] = (wpm_pkg::LEN_W'(k) < len_c);
      topbit[k]  = (wpm_pkg::LEN_W'(k + 1) == len_c);
    end
  end

  always_comb begin
    if (empty) begin
      cand_next = '0;
    end else begin
      cand_next = ((cand << 1) | CAP'(may_start)) & cmask & lenmask;
    end
  end

  assign hit   = ~empty & (|(cand_next & topbit));
  assign lm1   = OFFSET_BITS'(len_c) - OFFSET_BITS'(1);
  assign start = (pos >= lm1) ? (pos - lm1) : '0;

endmodule

// ----- design/word_prefix_text_matcher_core.sv -----
// ---------------------------------------------------------------------------
// word_prefix_text_matcher_core
// Case-insensitive streaming needle search with optional word-start gating.
// ---------------------------------------------------------------------------
// Throughput: one text byte per cycle; s_tready drops only while a result
//   beat is held and the byte waiting in the input register ends a haystack.
// Result path: a haystack's last byte passes the input register, then the match
//   logic into the result register; a held result beat can stall it in between.
// Reset: synchronous; clears needle registers, all haystack state and both
//   valid flags.
module word_prefix_text_matcher_core #(
  parameter int NEEDLE_MAX  = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wpm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wpm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wpm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  // text in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] text_byte
  input  logic                               s_tlast,   // last_byte
  // result out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [23:0]                        m_tdata    // [0] found, [16:1] match_offset,
                                                        // [17] overrun, [23:18] zero
);

  localparam int CAP = (NEEDLE_MAX < wpm_pkg::NEEDLE_BYTES) ? NEEDLE_MAX
                                                             : wpm_pkg::NEEDLE_BYTES;

  wpm_pkg::wpm_cfg_t cfg;

  // input register
  logic                    in_valid;
  logic [7:0]              in_byte;
  logic                    in_last;
  logic                    advance;

  // haystack state
  logic [CAP-1:0]          cand;
  logic [OFFSET_BITS-1:0]  byte_position;
  logic                    prior_alnum;
  logic                    match_seen;
  logic [OFFSET_BITS-1:0]  first_start;
  logic                    overrun_seen;

  // match logic
  logic [CAP-1:0]          cand_next;
  logic                    hit;
  logic                    empty;
  logic [OFFSET_BITS-1:0]  start;
  logic                    alnum;
  logic                    sat;
  logic                    match_seen_next;
  logic [OFFSET_BITS-1:0]  first_start_next;
  logic                    overrun_next;
  logic [31:0]             start_ext;

  // result register
  logic                    out_found;
  logic [wpm_pkg::MATCH_OFF_W-1:0] out_offset;
  logic                    out_overrun;

  wpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wpm_match #(
    .CAP         (CAP),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .cfg         (cfg),
    .text_byte   (in_byte),
    .cand        (cand),
    .prior_alnum (prior_alnum),
    .pos         (byte_position),
    .cand_next   (cand_next),
    .hit         (hit),
    .empty       (empty),
    .start       (start),
    .alnum       (alnum)
  );

  assign advance  = in_valid & (~in_last | ~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[7:0];
      in_last <= s_tlast;
    end
  end

  assign sat          = &byte_position;
  assign overrun_next = overrun_seen | sat;

  always_comb begin
    match_seen_next  = match_seen;
    first_start_next = first_start;
    if (empty) begin
      match_seen_next  = 1'b1;
      first_start_next = '0;
    end else if (!match_seen && hit) begin
      match_seen_next  = 1'b1;
      first_start_next = start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand          <= '0;
      byte_position <= '0;
      prior_alnum   <= 1'b0;
      match_seen    <= 1'b0;
      first_start   <= '0;
      overrun_seen  <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        cand          <= '0;
        byte_position <= '0;
        prior_alnum   <= 1'b0;
        match_seen    <= 1'b0;
        first_start   <= '0;
        overrun_seen  <= 1'b0;
      end else begin
        cand          <= cand_next;
        byte_position <= sat ? byte_position : byte_position + OFFSET_BITS'(1);
        prior_alnum   <= alnum;
        match_seen    <= match_seen_next;
        first_start   <= first_start_next;
        overrun_seen  <= overrun_next;
      end
    end
  end

  assign start_ext = 32'(first_start_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_found   <= match_seen_next;
      out_offset  <= match_seen_next ? start_ext[wpm_pkg::MATCH_OFF_W-1:0] : '0;
      out_overrun <= overrun_next;
    end
  end

  assign m_tdata = {6'd0, out_overrun, out_offset, out_found};

  // assertions
  a_no_offset_without_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || (m_tdata[16:1] == '0)))
    else $error("match offset nonzero on a result without a match");

  a_position_moves: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_last) |=> (byte_position != '0))
    else $error("byte position zero after a mid-haystack byte");

  a_empty_needle_no_cand: assert property (@(posedge clk) disable iff (rst)
    (advance && cfg.length == '0) |=> (cand == '0))
    else $error("candidates live with an empty needle");

  a_overrun_sticky: assert property (@(posedge clk) disable iff (rst)
    (overrun_seen && !(advance && in_last)) |=> overrun_seen)
    else $error("overrun flag dropped inside a haystack");

endmodule
